// ===== rtl/delta_list_timer_queue_macros.svh =====
// Assertion macros for the timer queue. Empty under synthesis.
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define DLTQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dltq assertion failed");
`define DLTQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dltq assertion failed");
`else
`define DLTQ_ASSERT_IMP(label, ante, cons)
`define DLTQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/dltq_pkg.sv =====
`timescale 1ns / 1ps
package dltq_pkg;

    localparam int REQ_OWNER_W = 8;
    localparam int REQ_TIME_W  = 16;
    localparam int WIDE_W      = 32;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    localparam logic EV_EXPIRE = 1'b0;
    localparam logic EV_REJECT = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [REQ_OWNER_W-1:0] owner_id;
        logic [REQ_TIME_W-1:0]  delay_ticks;
    } dltq_req_t;

    typedef struct packed {
        logic                   event_kind;
        logic [REQ_OWNER_W-1:0] expired_id;
    } dltq_rsp_t;

endpackage

// ===== rtl/dltq_step_unit.sv =====
`timescale 1ns / 1ps
// One walk step: remaining delta of an entry vs. the delay still to place.
module dltq_step_unit #(
    parameter int TIME_BITS = 16
) (
    input  logic [TIME_BITS-1:0] delta,
    input  logic [TIME_BITS-1:0] lead,
    input  logic [TIME_BITS-1:0] rem,
    output logic                 rem_lt,
    output logic [TIME_BITS-1:0] succ_delta,
    output logic [TIME_BITS-1:0] rem_after
);

    logic [TIME_BITS-1:0] eff;

    assign eff        = (delta > lead) ? (delta - lead) : '0;
    assign rem_lt     = rem < eff;
    assign succ_delta = eff - rem;
    assign rem_after  = rem - eff;

endmodule

// ===== rtl/delta_list_timer_queue.sv =====
`timescale 1ns / 1ps
// Tick: busy in ST_TICK; an expiry strobe, if the head entry is due, is registered out of ST_TICK.
// A tick on an empty queue is ignored, with no busy time. Full start: reject strobe in the cycle
// after accept, no busy time. Start: busy while walking past entries and moving entries toward
// the tail (queue memory: one read, one write per cycle). Results cannot be stalled.
// Reset (async, active low) empties the queue and clears the elapsed count; no clearing pass.
`include "delta_list_timer_queue_macros.svh"
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 16,
    parameter int OWNER_BITS  = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  dltq_req_t req,
    output logic      rsp_valid,
    output dltq_rsp_t rsp
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = OWNER_BITS + TIME_BITS;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_TICK     = 6'b000010,
        ST_WALK     = 6'b000100,
        ST_SHIFT_RD = 6'b001000,
        ST_SHIFT_WR = 6'b010000,
        ST_INSERT   = 6'b100000
    } state_t;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : IDX_W'(p + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
        return (p == '0) ? IDX_W'(QUEUE_DEPTH - 1) : IDX_W'(p - 1'b1);
    endfunction

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     head_ptr_reg, head_ptr_next;
    logic [IDX_W-1:0]     tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]     walk_idx_reg, walk_idx_next;
    logic [IDX_W-1:0]     walk_ptr_reg, walk_ptr_next;
    logic [IDX_W-1:0]     wptr_reg, wptr_next;
    logic [CNT_W-1:0]     mv_cnt_reg, mv_cnt_next;
    logic                 head_ins_reg, head_ins_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [TIME_BITS-1:0]  lead_reg, lead_next;
    logic [TIME_BITS-1:0]  rem_reg, rem_next;
    logic [TIME_BITS-1:0]  succ_reg, succ_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    dltq_rsp_t             rsp_reg, rsp_next;
    logic [ENTRY_W-1:0]    rd_data_reg;

    logic [ENTRY_W-1:0]    mem [QUEUE_DEPTH];
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [IDX_W-1:0]      rd_addr;

    logic                  accept;
    logic [WIDE_W-1:0]     owner_wide;
    logic [WIDE_W-1:0]     delay_wide;
    logic [OWNER_BITS-1:0] owner_in;
    logic [TIME_BITS-1:0]  delay_in;
    logic [WIDE_W-1:0]     rej_wide;
    logic [WIDE_W-1:0]     exp_wide;
    logic [OWNER_BITS-1:0] rd_owner;
    logic [TIME_BITS-1:0]  rd_delta;
    logic [TIME_BITS-1:0]  elapsed_inc;
    logic                  step_lt;
    logic [TIME_BITS-1:0]  step_succ;
    logic [TIME_BITS-1:0]  step_rem;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign owner_wide  = WIDE_W'(req.owner_id);
    assign delay_wide  = WIDE_W'(req.delay_ticks);
    assign owner_in    = owner_wide[OWNER_BITS-1:0];
    assign delay_in    = delay_wide[TIME_BITS-1:0];
    assign rej_wide    = WIDE_W'(owner_in);
    assign rd_owner    = rd_data_reg[ENTRY_W-1:TIME_BITS];
    assign rd_delta    = rd_data_reg[TIME_BITS-1:0];
    assign exp_wide    = WIDE_W'(rd_owner);
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : TIME_BITS'(elapsed_reg + 1'b1);

    dltq_step_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .delta      (rd_delta),
        .lead       (lead_reg),
        .rem        (rem_reg),
        .rem_lt     (step_lt),
        .succ_delta (step_succ),
        .rem_after  (step_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_ptr_next  = head_ptr_reg;
        tail_ptr_next  = tail_ptr_reg;
        count_next     = count_reg;
        elapsed_next   = elapsed_reg;
        walk_idx_next  = walk_idx_reg;
        walk_ptr_next  = walk_ptr_reg;
        wptr_next      = wptr_reg;
        mv_cnt_next    = mv_cnt_reg;
        head_ins_next  = head_ins_reg;
        rsp_valid_next = 1'b0;
        lead_next      = lead_reg;
        rem_next       = rem_reg;
        succ_next      = succ_reg;
        owner_next     = owner_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = wptr_reg;
        mem_wdata      = {owner_reg, rem_reg};
        rd_addr        = head_ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == MODE_TICK)
                    begin
                        if (count_reg != '0)
                        begin
                            elapsed_next = elapsed_inc;
                            state_next   = ST_TICK;
                        end
                    end
                    else if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        rsp_valid_next      = 1'b1;
                        rsp_next.event_kind = EV_REJECT;
                        rsp_next.expired_id = rej_wide[REQ_OWNER_W-1:0];
                    end
                    else
                    begin
                        owner_next    = owner_in;
                        rem_next      = delay_in;
                        lead_next     = elapsed_reg;
                        walk_idx_next = '0;
                        walk_ptr_next = head_ptr_reg;
                        state_next    = ST_WALK;
                    end
                end
            end
            ST_TICK:
            begin
                if (elapsed_reg >= rd_delta)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.event_kind = EV_EXPIRE;
                    rsp_next.expired_id = exp_wide[REQ_OWNER_W-1:0];
                    head_ptr_next       = ptr_inc(head_ptr_reg);
                    count_next          = CNT_W'(count_reg - 1'b1);
                    elapsed_next        = '0;
                end
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                priority if (walk_idx_reg == count_reg)
                begin
                    wptr_next     = tail_ptr_reg;
                    head_ins_next = (walk_idx_reg == '0);
                    state_next    = ST_INSERT;
                end
                else if (step_lt)
                begin
                    succ_next     = step_succ;
                    head_ins_next = (walk_idx_reg == '0);
                    wptr_next     = tail_ptr_reg;
                    mv_cnt_next   = CNT_W'(count_reg - walk_idx_reg);
                    state_next    = ST_SHIFT_RD;
                end
                else
                begin
                    rem_next      = step_rem;
                    lead_next     = '0;
                    walk_idx_next = CNT_W'(walk_idx_reg + 1'b1);
                    walk_ptr_next = ptr_inc(walk_ptr_reg);
                    rd_addr       = ptr_inc(walk_ptr_reg);
                end
            end
            ST_SHIFT_RD:
            begin
                rd_addr    = ptr_dec(wptr_reg);
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                // last move carries the successor with its reduced delta
                mem_we      = 1'b1;
                mem_wdata   = (mv_cnt_reg == CNT_W'(1)) ? {rd_owner, succ_reg} : rd_data_reg;
                wptr_next   = ptr_dec(wptr_reg);
                mv_cnt_next = CNT_W'(mv_cnt_reg - 1'b1);
                state_next  = (mv_cnt_reg == CNT_W'(1)) ? ST_INSERT : ST_SHIFT_RD;
            end
            ST_INSERT:
            begin
                mem_we        = 1'b1;
                count_next    = CNT_W'(count_reg + 1'b1);
                tail_ptr_next = ptr_inc(tail_ptr_reg);
                if (head_ins_reg)
                begin
                    elapsed_next = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_ptr_reg  <= '0;
            tail_ptr_reg  <= '0;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            walk_idx_reg  <= '0;
            walk_ptr_reg  <= '0;
            wptr_reg      <= '0;
            mv_cnt_reg    <= '0;
            head_ins_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_ptr_reg  <= head_ptr_next;
            tail_ptr_reg  <= tail_ptr_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            walk_idx_reg  <= walk_idx_next;
            walk_ptr_reg  <= walk_ptr_next;
            wptr_reg      <= wptr_next;
            mv_cnt_reg    <= mv_cnt_next;
            head_ins_reg  <= head_ins_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lead_reg  <= lead_next;
        rem_reg   <= rem_next;
        succ_reg  <= succ_next;
        owner_reg <= owner_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    `DLTQ_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `DLTQ_ASSERT_IMP(a_empty_no_elapsed, (state_reg == ST_IDLE) && (count_reg == '0), elapsed_reg == '0)
    `DLTQ_ASSERT_IMP(a_reject_when_full, rsp_valid_reg && (rsp_reg.event_kind == EV_REJECT), $past(count_reg) == CNT_W'(QUEUE_DEPTH))
    `DLTQ_ASSERT_IMP(a_expire_from_tick, rsp_valid_reg && (rsp_reg.event_kind == EV_EXPIRE), $past(state_reg) == ST_TICK)
    `DLTQ_ASSERT_NXT(a_insert_grows, state_reg == ST_INSERT, count_reg == CNT_W'($past(count_reg) + 1'b1))

endmodule

// ===== tb/tb_delta_list_timer_queue.sv =====
`timescale 1ns / 1ps
module tb_delta_list_timer_queue;
    import dltq_pkg::*;

    localparam int Q_DEPTH       = 16;
    localparam int DRAIN_CYCLES  = 60;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int RANDOM_ITEMS  = 1025;
    localparam int SCRIPT_ROWS   = 25;
    localparam logic [REQ_TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic                   mode;
        logic [REQ_OWNER_W-1:0] owner;
        logic [REQ_TIME_W-1:0]  delay;
        logic                   pinned;
        logic                   hit;
        logic                   kind;
        logic [REQ_OWNER_W-1:0] id;
    } script_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    dltq_req_t req = '0;
    logic      rsp_valid;
    dltq_rsp_t rsp;

    delta_list_timer_queue uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the timer queue
    logic [REQ_OWNER_W-1:0] slot_owner [Q_DEPTH];
    logic [REQ_TIME_W-1:0]  slot_delta [Q_DEPTH];
    int unsigned            live_cnt = 0;
    logic [REQ_TIME_W-1:0]  head_ticks = '0;

    dltq_rsp_t   pending_events [$];
    script_row_t script [SCRIPT_ROWS];

    int err_cnt = 0;
    int n_ticks = 0;
    int n_starts = 0;
    int n_effective = 0;
    int n_expired = 0;
    int n_rejected = 0;
    int idle_run = 0;
    dltq_rsp_t want;

    function automatic bit next_timer_event(input dltq_req_t r, output dltq_rsp_t ev);
        int unsigned i;
        int unsigned pos;
        logic [REQ_TIME_W-1:0] rem;
        logic [REQ_TIME_W-1:0] lead;
        logic [REQ_TIME_W-1:0] d;
        ev = '0;
        if (r.mode == MODE_TICK)
        begin
            if (live_cnt == 0)
                return 1'b0;
            if (head_ticks != TIME_MAX)
                head_ticks = head_ticks + 1'b1;
            if (head_ticks < slot_delta[0])
                return 1'b0;
            ev.event_kind = EV_EXPIRE;
            ev.expired_id = slot_owner[0];
            for (i = 1; i < live_cnt; i++)
            begin
                slot_owner[i-1] = slot_owner[i];
                slot_delta[i-1] = slot_delta[i];
            end
            live_cnt--;
            head_ticks = '0;
            return 1'b1;
        end
        if (live_cnt >= Q_DEPTH)
        begin
            ev.event_kind = EV_REJECT;
            ev.expired_id = r.owner_id;
            return 1'b1;
        end
        lead = head_ticks;
        rem  = r.delay_ticks;
        pos  = live_cnt;
        for (i = 0; i < live_cnt; i++)
        begin
            d = (slot_delta[i] > lead) ? slot_delta[i] - lead : '0;
            if (rem < d)
            begin
                slot_delta[i] = d - rem;
                pos = i;
                break;
            end
            lead = '0;
            rem  = rem - d;
        end
        for (i = live_cnt; i > pos; i--)
        begin
            slot_owner[i] = slot_owner[i-1];
            slot_delta[i] = slot_delta[i-1];
        end
        slot_owner[pos] = r.owner_id;
        slot_delta[pos] = rem;
        live_cnt++;
        if (pos == 0)
            head_ticks = '0;
        return 1'b0;
    endfunction

    function automatic dltq_req_t random_request(input int tick_pct);
        dltq_req_t r;
        int sel;
        r.mode     = ($urandom_range(0, 99) < tick_pct) ? MODE_TICK : MODE_START;
        r.owner_id = REQ_OWNER_W'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 80)
            r.delay_ticks = REQ_TIME_W'($urandom_range(0, 15));
        else if (sel < 97)
            r.delay_ticks = REQ_TIME_W'($urandom_range(0, 255));
        else if (sel < 98)
            r.delay_ticks = TIME_MAX;
        else
            r.delay_ticks = REQ_TIME_W'($urandom_range(0, 65535));
        return r;
    endfunction

    task automatic send_item(input dltq_req_t item, input bit pinned, input bit pin_hit,
                             input dltq_rsp_t pin_ev);
        dltq_rsp_t ev;
        bit hit;
        req   <= item;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (!(item.mode == MODE_TICK && live_cnt == 0))
            n_effective++;
        hit = next_timer_event(item, ev);
        if (pinned)
        begin
            hit = pin_hit;
            ev  = pin_ev;
        end
        if (hit)
            pending_events.push_back(ev);
        if (item.mode == MODE_START)
            n_starts++;
        else
            n_ticks++;
    endtask

    task automatic sender_gap(input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic flag_mismatch(input bit have_exp, input dltq_rsp_t exp, input dltq_rsp_t got);
        err_cnt++;
        if (err_cnt <= 10)
        begin
            if (have_exp)
                $display("MISMATCH @%0t: exp kind=%0d id=%02h, got kind=%0d id=%02h",
                         $realtime, exp.event_kind, exp.expired_id, got.event_kind,
                         got.expired_id);
            else
                $display("MISMATCH @%0t: unexpected result kind=%0d id=%02h",
                         $realtime, got.event_kind, got.expired_id);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid)
        begin
            if (pending_events.size() == 0)
                flag_mismatch(1'b0, '0, rsp);
            else
            begin
                want = pending_events.pop_front();
                if (rsp.event_kind !== want.event_kind || rsp.expired_id !== want.expired_id)
                    flag_mismatch(1'b1, want, rsp);
                if (rsp.event_kind == EV_REJECT)
                    n_rejected++;
                else
                    n_expired++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || rsp_valid)
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
            if (idle_run >= WATCHDOG_MAX)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int phase;
        int gap_pct;
        int tick_pct;
        int target;
        dltq_rsp_t pin_ev;
        dltq_req_t r;

        script = '{
            {MODE_TICK,  8'h00, 16'h0000, 1'b1, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'hFF, 16'h0000, 1'b1, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_TICK,  8'h00, 16'h0000, 1'b1, 1'b1, EV_EXPIRE, 8'hFF},
            {MODE_TICK,  8'h00, 16'h0000, 1'b1, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h00, 16'hFFFF, 1'b1, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h01, 16'h0003, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h02, 16'h0003, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h03, 16'h0000, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_TICK,  8'h00, 16'h0000, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_TICK,  8'h00, 16'h0000, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h10, 16'h0001, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h21, 16'h0002, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h42, 16'hFFFF, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h84, 16'h0005, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h5A, 16'h0000, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h3C, 16'h0003, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'hC3, 16'h0064, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h7E, 16'h0002, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h81, 16'h0007, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h18, 16'hFFFE, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'hE7, 16'h0004, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h66, 16'h0001, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'h99, 16'h8009, 1'b0, 1'b0, EV_EXPIRE, 8'h00},
            {MODE_START, 8'hA5, 16'h1234, 1'b1, 1'b1, EV_REJECT, 8'hA5},
            {MODE_TICK,  8'h00, 16'h0000, 1'b0, 1'b0, EV_EXPIRE, 8'h00}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < SCRIPT_ROWS; i++)
        begin
            r.mode        = script[i].mode;
            r.owner_id    = script[i].owner;
            r.delay_ticks = script[i].delay;
            pin_ev.event_kind = script[i].kind;
            pin_ev.expired_id = script[i].id;
            send_item(r, script[i].pinned, script[i].hit, pin_ev);
        end
        wait_drained();

        // random traffic: sender idles 37%, then 58%, then never
        n_effective = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 37 : (phase == 1) ? 58 : 0;
            target  = (RANDOM_ITEMS * (phase + 1)) / 3;
            tick_pct = 50;
            while (n_effective < target)
            begin
                if ($urandom_range(0, 49) == 0)
                    tick_pct = ($urandom_range(0, 2) == 0) ? 20 :
                               ($urandom_range(0, 1) == 0) ? 50 : 80;
                if (phase != 2 || $urandom_range(0, 3) == 0)
                    sender_gap(gap_pct);
                send_item(random_request(tick_pct), 1'b0, 1'b0, '0);
            end
            if (phase != 2)
                wait_drained();
        end

        wait_drained();
        if (pending_events.size() != 0)
        begin
            err_cnt += pending_events.size();
            $display("%0d expected results never arrived", pending_events.size());
        end
        $display("covered %0d transactions: %0d ticks, %0d starts", n_ticks + n_starts,
                 n_ticks, n_starts);
        $display("results checked: %0d expiries, %0d full-queue rejects, %0d errors",
                 n_expired, n_rejected, err_cnt);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
